/* hw/rtl/cvc_pkg.sv */
// shared types, constants and codon translation for the coding variant classifier
package cvc_pkg;

   localparam int unsigned BLOCK_LEN_MAX_DEF  = 65535;
   localparam int unsigned ALLELE_LEN_MAX_DEF = 1023;

   localparam int POS_W    = 16;
   localparam int BLEN_W   = 16;
   localparam int ALLELE_W = 10;
   localparam int BASE_W   = 8;
   localparam int CQ_W     = 4;

   // reciprocal of three for 16 bit values: q = (x * 43691) >> 17
   localparam int                RECIP16_W     = 17;
   localparam logic [RECIP16_W-1:0] RECIP16    = 17'd43691;
   localparam int                PROD16_W      = POS_W + RECIP16_W;
   // reciprocal of three for 10 bit values: q = (x * 683) >> 11
   localparam int                RECIP10_SHIFT = 11;
   localparam int                PROD10_W      = 21;
   localparam logic [PROD10_W-1:0] RECIP10     = 21'd683;

   typedef enum logic [CQ_W-1:0] {
      CQ_SPLICE        = 4'd0,
      CQ_FRAMESHIFT    = 4'd1,
      CQ_INFRAME_DEL   = 4'd2,
      CQ_INFRAME_INS   = 4'd3,
      CQ_REFERENCE     = 4'd4,
      CQ_STOP_RETAINED = 4'd5,
      CQ_STOP_LOST     = 4'd6,
      CQ_NONSENSE      = 4'd7,
      CQ_SYNONYMOUS    = 4'd8,
      CQ_MISSENSE      = 4'd9,
      CQ_COMPLEX       = 4'd10
   } consequence_type;

   localparam logic [BASE_W-1:0] AA_STOP    = 8'h2A; // '*'
   localparam logic [BASE_W-1:0] AA_UNKNOWN = 8'h58; // 'X'

   // standard genetic code, entry i at the i-th character, A=0 C=1 G=2 T=3
   localparam logic [8*64-1:0] AMINO_STR =
      "KNKNTTTTRSRSIIMIQHQHPPPPRRRRLLLLEDEDAAAAGGGGVVVV*Y*YSSSS*CWCLFLF";

   // top bit flags a byte that is no base
   function automatic logic [2:0] base_code(input logic [BASE_W-1:0] b);
      logic [2:0] c;
      case (b)
         8'h41, 8'h61:               c = 3'd0;
         8'h43, 8'h63:               c = 3'd1;
         8'h47, 8'h67:               c = 3'd2;
         8'h54, 8'h74, 8'h55, 8'h75: c = 3'd3;
         default:                    c = 3'd4;
      endcase
      return c;
   endfunction

   function automatic logic [BASE_W-1:0] translate(input logic [BASE_W-1:0] b0,
                                                   input logic [BASE_W-1:0] b1,
                                                   input logic [BASE_W-1:0] b2);
      logic [2:0] c0;
      logic [2:0] c1;
      logic [2:0] c2;
      logic [5:0] idx;
      logic [BASE_W-1:0] aa;
      c0  = base_code(b0);
      c1  = base_code(b1);
      c2  = base_code(b2);
      idx = {c0[1:0], c1[1:0], c2[1:0]};
      if (c0[2] || c1[2] || c2[2]) begin
         aa = AA_UNKNOWN;
      end else begin
         aa = AMINO_STR[{~idx, 3'b000} +: 8];
      end
      return aa;
   endfunction

   // after the front stage: reciprocal products, length compare, codon translations
   typedef struct packed {
      logic [POS_W-1:0]    pos;
      logic [PROD16_W-1:0] pos_prod;
      logic [PROD16_W-1:0] blen_prod;
      logic                ref_longer;
      logic                ref_shorter;
      logic [ALLELE_W-1:0] len_diff;
      logic [ALLELE_W-1:0] ref_len;
      logic [BASE_W-1:0]   aa_ref;
      logic [2:0][BASE_W-1:0] aa_mut;
      logic [2:0]          base_eq;
   } front_type;

   // after the codon stage: everything the final priority select needs
   typedef struct packed {
      logic              splice;
      logic              ref_longer;
      logic              ref_shorter;
      logic              diff_not_mult3;
      logic              ref_len_one;
      logic              ref_not_mult3;
      logic              base_eq;
      logic [BASE_W-1:0] aa_ref;
      logic [BASE_W-1:0] aa_mut;
   } codon_type;

endpackage

/* hw/rtl/cvc_front.sv */
// first stage: length saturation, reciprocal products and codon translations
module cvc_front #(
   parameter int unsigned BLOCK_LEN_MAX  = cvc_pkg::BLOCK_LEN_MAX_DEF,
   parameter int unsigned ALLELE_LEN_MAX = cvc_pkg::ALLELE_LEN_MAX_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  logic [cvc_pkg::POS_W-1:0]     variant_position,
   input  logic [cvc_pkg::BLEN_W-1:0]    coding_length,
   input  logic [cvc_pkg::ALLELE_W-1:0]  ref_allele_length,
   input  logic [cvc_pkg::ALLELE_W-1:0]  alt_allele_length,
   input  logic [cvc_pkg::BASE_W-1:0]    codon_first_base,
   input  logic [cvc_pkg::BASE_W-1:0]    codon_second_base,
   input  logic [cvc_pkg::BASE_W-1:0]    codon_third_base,
   input  logic [cvc_pkg::BASE_W-1:0]    alt_first_base,
   output logic                          out_valid,
   input  logic                          out_ready,
   output cvc_pkg::front_type            out_data
);

   logic                         valid_ff;
   logic                         valid_in;
   cvc_pkg::front_type           data_ff;
   cvc_pkg::front_type           data_in;
   logic [cvc_pkg::BLEN_W-1:0]   blen_sat;
   logic [cvc_pkg::ALLELE_W-1:0] rlen_sat;
   logic [cvc_pkg::ALLELE_W-1:0] alen_sat;

   assign in_ready = !valid_ff || out_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   always_comb begin
      blen_sat = (32'(coding_length) > BLOCK_LEN_MAX) ?
                 cvc_pkg::BLEN_W'(BLOCK_LEN_MAX) : coding_length;
      rlen_sat = (32'(ref_allele_length) > ALLELE_LEN_MAX) ?
                 cvc_pkg::ALLELE_W'(ALLELE_LEN_MAX) : ref_allele_length;
      alen_sat = (32'(alt_allele_length) > ALLELE_LEN_MAX) ?
                 cvc_pkg::ALLELE_W'(ALLELE_LEN_MAX) : alt_allele_length;

      data_in.pos         = variant_position;
      data_in.pos_prod    = cvc_pkg::PROD16_W'(variant_position) *
                            cvc_pkg::PROD16_W'(cvc_pkg::RECIP16);
      data_in.blen_prod   = cvc_pkg::PROD16_W'(blen_sat) *
                            cvc_pkg::PROD16_W'(cvc_pkg::RECIP16);
      data_in.ref_longer  = rlen_sat > alen_sat;
      data_in.ref_shorter = rlen_sat < alen_sat;
      data_in.len_diff    = (rlen_sat > alen_sat) ? (rlen_sat - alen_sat) :
                                                    (alen_sat - rlen_sat);
      data_in.ref_len     = rlen_sat;

      // reference codon and the three possible mutated codons
      data_in.aa_ref    = cvc_pkg::translate(codon_first_base, codon_second_base,
                                             codon_third_base);
      data_in.aa_mut[0] = cvc_pkg::translate(alt_first_base, codon_second_base,
                                             codon_third_base);
      data_in.aa_mut[1] = cvc_pkg::translate(codon_first_base, alt_first_base,
                                             codon_third_base);
      data_in.aa_mut[2] = cvc_pkg::translate(codon_first_base, codon_second_base,
                                             alt_first_base);
      data_in.base_eq[0] = codon_first_base == alt_first_base;
      data_in.base_eq[1] = codon_second_base == alt_first_base;
      data_in.base_eq[2] = codon_third_base == alt_first_base;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

/* hw/rtl/cvc_codon.sv */
// second stage: codon index and offset, splice test, modulo three, offset select
module cvc_codon (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  cvc_pkg::front_type  in_data,
   output logic                out_valid,
   input  logic                out_ready,
   output cvc_pkg::codon_type  out_data
);

   localparam int QW = cvc_pkg::POS_W;
   localparam int AW = cvc_pkg::ALLELE_W;

   logic                          valid_ff;
   logic                          valid_in;
   cvc_pkg::codon_type            data_ff;
   cvc_pkg::codon_type            data_in;
   logic [QW-1:0]                 codon_idx;
   logic [QW-1:0]                 codon_count;
   logic [1:0]                    offset;
   logic [cvc_pkg::PROD10_W-1:0]  diff_prod;
   logic [cvc_pkg::PROD10_W-1:0]  rlen_prod;
   logic [AW-1:0]                 diff_q;
   logic [AW-1:0]                 rlen_q;
   logic [1:0]                    diff_mod;
   logic [1:0]                    rlen_mod;

   assign in_ready = !valid_ff || out_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   always_comb begin
      codon_idx   = in_data.pos_prod[cvc_pkg::PROD16_W-1 -: QW];
      codon_count = in_data.blen_prod[cvc_pkg::PROD16_W-1 -: QW];
      offset      = 2'(in_data.pos - QW'({codon_idx, 1'b0} + {1'b0, codon_idx}));

      diff_prod = cvc_pkg::PROD10_W'(in_data.len_diff) * cvc_pkg::RECIP10;
      rlen_prod = cvc_pkg::PROD10_W'(in_data.ref_len) * cvc_pkg::RECIP10;
      diff_q    = diff_prod[cvc_pkg::RECIP10_SHIFT +: AW];
      rlen_q    = rlen_prod[cvc_pkg::RECIP10_SHIFT +: AW];
      diff_mod  = 2'(in_data.len_diff - AW'({diff_q, 1'b0} + {1'b0, diff_q}));
      rlen_mod  = 2'(in_data.ref_len - AW'({rlen_q, 1'b0} + {1'b0, rlen_q}));

      // first codon, or last codon when the block holds one
      data_in.splice = (codon_idx == '0) ||
                       ((QW + 1)'(codon_idx) + (QW + 1)'(1) == (QW + 1)'(codon_count));
      data_in.ref_longer     = in_data.ref_longer;
      data_in.ref_shorter    = in_data.ref_shorter;
      data_in.diff_not_mult3 = diff_mod != 2'd0;
      data_in.ref_len_one    = in_data.ref_len == AW'(1);
      data_in.ref_not_mult3  = rlen_mod != 2'd0;
      data_in.aa_ref         = in_data.aa_ref;

      case (offset)
         2'd0: begin
            data_in.base_eq = in_data.base_eq[0];
            data_in.aa_mut  = in_data.aa_mut[0];
         end
         2'd1: begin
            data_in.base_eq = in_data.base_eq[1];
            data_in.aa_mut  = in_data.aa_mut[1];
         end
         default: begin
            data_in.base_eq = in_data.base_eq[2];
            data_in.aa_mut  = in_data.aa_mut[2];
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

/* hw/rtl/cvc_resolve.sv */
// third stage: priority select of the consequence class into the output register
module cvc_resolve (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         in_valid,
   output logic                         in_ready,
   input  cvc_pkg::codon_type           in_data,
   output logic                         out_valid,
   input  logic                         out_stall,
   output cvc_pkg::consequence_type     out_consequence
);

   logic                      valid_ff;
   logic                      valid_in;
   cvc_pkg::consequence_type  cq_ff;
   cvc_pkg::consequence_type  cq_in;
   logic                      ref_stop;
   logic                      mut_stop;

   assign in_ready = !valid_ff || !out_stall;
   assign valid_in = in_ready ? in_valid : valid_ff;

   always_comb begin
      ref_stop = in_data.aa_ref == cvc_pkg::AA_STOP;
      mut_stop = in_data.aa_mut == cvc_pkg::AA_STOP;
      if (in_data.splice) begin
         cq_in = cvc_pkg::CQ_SPLICE;
      end else if (in_data.ref_longer) begin
         cq_in = in_data.diff_not_mult3 ? cvc_pkg::CQ_FRAMESHIFT : cvc_pkg::CQ_INFRAME_DEL;
      end else if (in_data.ref_shorter) begin
         cq_in = in_data.diff_not_mult3 ? cvc_pkg::CQ_FRAMESHIFT : cvc_pkg::CQ_INFRAME_INS;
      end else if (in_data.ref_len_one) begin
         if (in_data.base_eq) begin
            cq_in = cvc_pkg::CQ_REFERENCE;
         end else if (ref_stop) begin
            cq_in = mut_stop ? cvc_pkg::CQ_STOP_RETAINED : cvc_pkg::CQ_STOP_LOST;
         end else if (mut_stop) begin
            cq_in = cvc_pkg::CQ_NONSENSE;
         end else if (in_data.aa_ref == in_data.aa_mut) begin
            cq_in = cvc_pkg::CQ_SYNONYMOUS;
         end else begin
            cq_in = cvc_pkg::CQ_MISSENSE;
         end
      end else if (in_data.ref_not_mult3) begin
         cq_in = cvc_pkg::CQ_FRAMESHIFT;
      end else begin
         cq_in = cvc_pkg::CQ_COMPLEX;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         cq_ff <= cq_in;
      end
   end

   assign out_valid       = valid_ff;
   assign out_consequence = cq_ff;

endmodule

/* hw/rtl/coding_variant_classifier.sv */
// top level of the coding variant consequence classifier
// Classifies one coding variant per item into a consequence class (splice, frameshift,
// in-frame deletion or insertion, reference, stop retained, stop lost, nonsense,
// synonymous, missense, complex). The block is a three-stage pipeline: reciprocal
// products and codon translations, then codon index, offset and modulo-three tests,
// then the priority select into the output register. An item can be taken every cycle
// while the result side does not stall, and it passes the front, codon and resolve
// registers in order; each stage holds its item under stall, empty stages keep filling,
// so the input stalls only once all three stages hold items. Lengths above the parameters
// are clamped to them.
module coding_variant_classifier #(
   parameter int unsigned BLOCK_LEN_MAX  = cvc_pkg::BLOCK_LEN_MAX_DEF,
   parameter int unsigned ALLELE_LEN_MAX = cvc_pkg::ALLELE_LEN_MAX_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [cvc_pkg::POS_W-1:0]     req_variant_position,
   input  logic [cvc_pkg::BLEN_W-1:0]    req_coding_length,
   input  logic [cvc_pkg::ALLELE_W-1:0]  req_ref_allele_length,
   input  logic [cvc_pkg::ALLELE_W-1:0]  req_alt_allele_length,
   input  logic [cvc_pkg::BASE_W-1:0]    req_codon_first_base,
   input  logic [cvc_pkg::BASE_W-1:0]    req_codon_second_base,
   input  logic [cvc_pkg::BASE_W-1:0]    req_codon_third_base,
   input  logic [cvc_pkg::BASE_W-1:0]    req_alt_first_base,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [cvc_pkg::CQ_W-1:0]      rsp_consequence
);

   logic                      front_ready;
   logic                      front_valid;
   cvc_pkg::front_type        front_data;
   logic                      codon_ready;
   logic                      codon_valid;
   cvc_pkg::codon_type        codon_data;
   logic                      resolve_ready;
   cvc_pkg::consequence_type  consequence;

   cvc_front #(
      .BLOCK_LEN_MAX  (BLOCK_LEN_MAX),
      .ALLELE_LEN_MAX (ALLELE_LEN_MAX)
   ) u_front (
      .clock             (clock),
      .reset             (reset),
      .in_valid          (req_valid),
      .in_ready          (front_ready),
      .variant_position  (req_variant_position),
      .coding_length     (req_coding_length),
      .ref_allele_length (req_ref_allele_length),
      .alt_allele_length (req_alt_allele_length),
      .codon_first_base  (req_codon_first_base),
      .codon_second_base (req_codon_second_base),
      .codon_third_base  (req_codon_third_base),
      .alt_first_base    (req_alt_first_base),
      .out_valid         (front_valid),
      .out_ready         (codon_ready),
      .out_data          (front_data)
   );

   cvc_codon u_codon (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (front_valid),
      .in_ready  (codon_ready),
      .in_data   (front_data),
      .out_valid (codon_valid),
      .out_ready (resolve_ready),
      .out_data  (codon_data)
   );

   cvc_resolve u_resolve (
      .clock           (clock),
      .reset           (reset),
      .in_valid        (codon_valid),
      .in_ready        (resolve_ready),
      .in_data         (codon_data),
      .out_valid       (rsp_valid),
      .out_stall       (rsp_stall),
      .out_consequence (consequence)
   );

   assign req_stall       = !front_ready;
   assign rsp_consequence = consequence;

   // a free result side never backs up into the input
   assert property (@(posedge clock) disable iff (reset) !rsp_stall |-> !req_stall)
      else $error("input stalled with result side free");

   // an accepted item reaches the output when the result side does not stall on its way
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) ##1 !rsp_stall ##1 !rsp_stall |=> rsp_valid)
      else $error("item lost in pipeline");

   // only defined consequence codes leave the block
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_consequence <= cvc_pkg::CQ_COMPLEX))
      else $error("undefined consequence code");

endmodule
